// ----- sv/srs_pkg.sv -----
`timescale 1ns / 1ps
package srs_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUTER_RD,
		ST_OUTER_LD,
		ST_INNER,
		ST_GAP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} srs_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_SCAN,
		OP_OUTER_RD,
		OP_OUTER_LD,
		OP_INNER,
		OP_GAP,
		OP_DIV_GO,
		OP_OUT
	} srs_op_t;

	localparam logic [1:0] SEL_AVG = 2'd0;
	localparam logic [1:0] SEL_MAX = 2'd1;
	localparam logic [1:0] SEL_MIN = 2'd2;

	localparam logic [0:0] REG_WINDOW = 1'b0;
	localparam logic [0:0] REG_CAP    = 1'b1;

	localparam logic       CMD_RECORD = 1'b0;
	localparam logic       CMD_QUERY  = 1'b1;

	localparam logic [26:0] RATE_SCALE   = 27'd100000000;
	localparam logic [31:0] WINDOW_RESET = 32'd5000000;
	localparam logic [15:0] CAP_RESET    = 16'hffff;

	typedef struct packed {
		srs_op_t    op;
		logic       rec;
		logic [1:0] sel;
	} srs_cmd_t;

	typedef struct packed {
		logic fill_ge2;
		logic scan_done;
		logic i_last;
		logic div_busy;
		logic out_free;
	} srs_sts_t;

	function automatic logic [15:0] cap_rate(input logic [63:0] q, input logic [15:0] cap);
		logic [15:0] r;
		r = (q > {48'd0, cap}) ? cap : q[15:0];
		return r;
	endfunction

endpackage

// ----- sv/srs_div.sv -----
`timescale 1ns / 1ps
module srs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [64:0] part;
	logic        fit;
	logic [64:0] diff;

	assign part = {rem_q, quo_q[63]};
	assign fit  = part >= {1'b0, den_q};
	assign diff = part - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fit ? diff[63:0] : part[63:0];
			quo_q <= {quo_q[62:0], fit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/srs_dp.sv -----
`timescale 1ns / 1ps
module srs_dp #(
	parameter int DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  srs_pkg::srs_cmd_t cmd,
	output srs_pkg::srs_sts_t sts,
	input  logic [63:0]      time_us,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [47:0]      m_tdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = CW + 27;

	logic [63:0] ram [DEPTH];
	logic [63:0] rd_q;
	logic        rd_v_q;
	logic [AW-1:0] wr_slot_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] win_q;
	logic [15:0] cap_q;
	logic [63:0] now_q;
	logic [63:0] start_q;
	logic [63:0] old_q;
	logic [63:0] new_q;
	logic [63:0] a_q;
	logic        a_in_q;
	logic [63:0] succ_q;
	logic        succ_v_q;
	logic [63:0] gmin_q;
	logic [63:0] gmax_q;
	logic        gv_q;
	logic [1:0]  pend_q;
	logic [15:0] avg_q;
	logic [15:0] min_q;
	logic [15:0] max_q;
	logic        out_v_q;
	logic [47:0] out_q;

	logic [AW-1:0] rd_addr;
	logic        issue;
	logic        in_win;
	logic [63:0] diff;
	logic [CW-1:0] nm1;
	logic [PW-1:0] prod;
	logic        div_ok;
	logic [63:0] div_num;
	logic [63:0] div_den;
	logic        div_start;
	logic        div_busy;
	logic        div_done;
	logic [63:0] div_q;
	logic [15:0] div_cap;
	logic        out_free;
	logic [63:0] win_start;

	assign rd_addr = (cmd.op == srs_pkg::OP_OUTER_RD) ? i_q[AW-1:0] : j_q[AW-1:0];
	assign issue = ((cmd.op == srs_pkg::OP_SCAN) || (cmd.op == srs_pkg::OP_INNER))
		&& (j_q < fill_q);
	assign in_win = (rd_q >= start_q) && (rd_q <= now_q);
	assign diff = rd_q - a_q;
	assign nm1 = cnt_q - CW'(1);
	assign prod = PW'(nm1) * PW'(srs_pkg::RATE_SCALE);
	assign out_free = !out_v_q || m_tready;
	assign win_start = (time_us > {32'd0, win_q}) ? (time_us - {32'd0, win_q}) : 64'd0;
	assign div_cap = srs_pkg::cap_rate(div_q, cap_q);

	always_comb begin
		div_ok  = 1'b0;
		div_num = 64'(srs_pkg::RATE_SCALE);
		div_den = gmin_q;
		unique case (cmd.sel)
			srs_pkg::SEL_AVG: begin
				div_ok  = (cnt_q >= CW'(2)) && (new_q > old_q);
				div_num = 64'(prod);
				div_den = new_q - old_q;
			end
			srs_pkg::SEL_MAX: begin
				div_ok  = gv_q;
				div_den = gmin_q;
			end
			srs_pkg::SEL_MIN: begin
				div_ok  = gv_q;
				div_den = gmax_q;
			end
			default: begin
				div_ok = 1'b0;
			end
		endcase
	end

	assign div_start = (cmd.op == srs_pkg::OP_DIV_GO) && div_ok;

	srs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (cmd.rec) begin
			ram[wr_slot_q] <= time_us;
		end
		rd_q <= ram[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			fill_q    <= '0;
			win_q     <= srs_pkg::WINDOW_RESET;
			cap_q     <= srs_pkg::CAP_RESET;
			rd_v_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					srs_pkg::REG_WINDOW: win_q <= cfg_data;
					srs_pkg::REG_CAP:    cap_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.rec) begin
				wr_slot_q <= (wr_slot_q == AW'(DEPTH - 1)) ? '0 : wr_slot_q + AW'(1);
				if (fill_q < CW'(DEPTH)) begin
					fill_q <= fill_q + CW'(1);
				end
			end
			rd_v_q <= issue;
			if (issue) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.op == srs_pkg::OP_START) begin
				i_q <= '0;
				j_q <= '0;
			end
			if (cmd.op == srs_pkg::OP_OUTER_RD) begin
				j_q <= '0;
			end
			if (cmd.op == srs_pkg::OP_GAP) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.op == srs_pkg::OP_OUT) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			srs_pkg::OP_START: begin
				now_q   <= time_us;
				start_q <= win_start;
				cnt_q   <= '0;
				gv_q    <= 1'b0;
				avg_q   <= '0;
				min_q   <= '0;
				max_q   <= '0;
			end
			srs_pkg::OP_SCAN: begin
				if (rd_v_q && in_win) begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == '0 || rd_q < old_q) old_q <= rd_q;
					if (cnt_q == '0 || rd_q > new_q) new_q <= rd_q;
				end
			end
			srs_pkg::OP_OUTER_LD: begin
				a_q      <= rd_q;
				a_in_q   <= in_win;
				succ_v_q <= 1'b0;
			end
			srs_pkg::OP_INNER: begin
				if (rd_v_q && in_win && (rd_q > a_q) && (!succ_v_q || diff < succ_q)) begin
					succ_q   <= diff;
					succ_v_q <= 1'b1;
				end
			end
			srs_pkg::OP_GAP: begin
				if (a_in_q && succ_v_q) begin
					gv_q <= 1'b1;
					if (!gv_q || succ_q < gmin_q) gmin_q <= succ_q;
					if (!gv_q || succ_q > gmax_q) gmax_q <= succ_q;
				end
			end
			srs_pkg::OP_DIV_GO: begin
				pend_q <= cmd.sel;
			end
			srs_pkg::OP_OUT: begin
				out_q <= {max_q, min_q, avg_q};
			end
			default: ;
		endcase
		if (div_done) begin
			unique case (pend_q)
				srs_pkg::SEL_AVG: avg_q <= div_cap;
				srs_pkg::SEL_MAX: max_q <= div_cap;
				srs_pkg::SEL_MIN: min_q <= div_cap;
				default: ;
			endcase
		end
	end

	assign sts.fill_ge2  = fill_q >= CW'(2);
	assign sts.scan_done = (j_q >= fill_q) && !rd_v_q;
	assign sts.i_last    = (i_q + CW'(1)) >= fill_q;
	assign sts.div_busy  = div_busy;
	assign sts.out_free  = out_free;

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

// ----- sv/srs_ctrl.sv -----
`timescale 1ns / 1ps
module srs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [0:0]        s_tuser,
	output logic              s_tready,
	input  srs_pkg::srs_sts_t sts,
	output srs_pkg::srs_cmd_t cmd
);

	srs_pkg::srs_state_t state_q;
	srs_pkg::srs_state_t state_d;
	logic [1:0] sel_q;
	logic       acc;

	assign acc = s_tvalid && (state_q == srs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srs_pkg::ST_IDLE;
			sel_q   <= srs_pkg::SEL_AVG;
		end else begin
			state_q <= state_d;
			if (state_q == srs_pkg::ST_IDLE) begin
				sel_q <= srs_pkg::SEL_AVG;
			end else if (state_q == srs_pkg::ST_DIV_WAIT && !sts.div_busy) begin
				sel_q <= sel_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srs_pkg::ST_IDLE: begin
				if (acc && s_tuser[0] == srs_pkg::CMD_QUERY) begin
					state_d = sts.fill_ge2 ? srs_pkg::ST_SCAN : srs_pkg::ST_OUT;
				end
			end
			srs_pkg::ST_SCAN: begin
				if (sts.scan_done) state_d = srs_pkg::ST_OUTER_RD;
			end
			srs_pkg::ST_OUTER_RD: state_d = srs_pkg::ST_OUTER_LD;
			srs_pkg::ST_OUTER_LD: state_d = srs_pkg::ST_INNER;
			srs_pkg::ST_INNER: begin
				if (sts.scan_done) state_d = srs_pkg::ST_GAP;
			end
			srs_pkg::ST_GAP: begin
				state_d = sts.i_last ? srs_pkg::ST_DIV_GO : srs_pkg::ST_OUTER_RD;
			end
			srs_pkg::ST_DIV_GO: state_d = srs_pkg::ST_DIV_WAIT;
			srs_pkg::ST_DIV_WAIT: begin
				if (!sts.div_busy) begin
					state_d = (sel_q == srs_pkg::SEL_MIN) ? srs_pkg::ST_OUT : srs_pkg::ST_DIV_GO;
				end
			end
			srs_pkg::ST_OUT: begin
				if (sts.out_free) state_d = srs_pkg::ST_IDLE;
			end
			default: state_d = srs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd.op   = srs_pkg::OP_NONE;
		cmd.rec  = 1'b0;
		cmd.sel  = sel_q;
		unique case (state_q)
			srs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (acc) begin
					if (s_tuser[0] == srs_pkg::CMD_QUERY) begin
						cmd.op = srs_pkg::OP_START;
					end else begin
						cmd.rec = 1'b1;
					end
				end
			end
			srs_pkg::ST_SCAN:     cmd.op = srs_pkg::OP_SCAN;
			srs_pkg::ST_OUTER_RD: cmd.op = srs_pkg::OP_OUTER_RD;
			srs_pkg::ST_OUTER_LD: cmd.op = srs_pkg::OP_OUTER_LD;
			srs_pkg::ST_INNER:    cmd.op = srs_pkg::OP_INNER;
			srs_pkg::ST_GAP:      cmd.op = srs_pkg::OP_GAP;
			srs_pkg::ST_DIV_GO:   cmd.op = srs_pkg::OP_DIV_GO;
			srs_pkg::ST_DIV_WAIT: cmd.op = srs_pkg::OP_NONE;
			srs_pkg::ST_OUT: begin
				if (sts.out_free) cmd.op = srs_pkg::OP_OUT;
			end
			default: cmd.op = srs_pkg::OP_NONE;
		endcase
	end

endmodule

// ----- sv/sample_rate_statistics.sv -----
`timescale 1ns / 1ps
// Sliding-window sample rate monitor. A record word (tuser 0) stores its timestamp in a
// DEPTH-entry ring. A query word (tuser 1) returns avg, min and max rates in centihertz
// over stamps in [now - window_length_us, now]. With fewer than two stored stamps a query
// goes straight to the output; otherwise it runs a window pass, then a neighbor-gap search
// (one ring read per cycle, single read port), then up to three divisions on one shared
// 64-bit radix-2 divider.
// A finished result sits in an output register while the next word is taken.
module sample_rate_statistics #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // time_us
	input  logic [0:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // avg_rate_chz, min_rate_chz, max_rate_chz
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	srs_pkg::srs_cmd_t cmd;
	srs_pkg::srs_sts_t sts;

	srs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srs_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.time_us   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- tb/tb_sample_rate_statistics.sv -----
`timescale 1ns / 1ps
module tb_sample_rate_statistics;

	typedef struct {
		logic        cmd;
		logic [63:0] stamp;
	} word_t;

	typedef struct {
		logic [15:0] avg;
		logic [15:0] min;
		logic [15:0] max;
	} rates_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // time_us
	logic [0:0]  s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // avg_rate_chz, min_rate_chz, max_rate_chz
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	sample_rate_statistics uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// settled block drain after the last result
	localparam int DRAIN = 1800;

	word_t       word_q[$];
	rates_t      rates_q[$];
	logic [63:0] stamps[32];
	logic [4:0]  slot;
	int          filled;
	logic [31:0] win_us;
	logic [15:0] cap;

	int  errs, queries_sent, records_sent, results_seen;
	int  tx_gap, rx_gap, hold_left;
	bit  tx_burst, rx_burst, hold_req, tx_taken, rx_taken;
	logic [63:0] t_cur;

	always begin
		#1 clk = 1'b0;
		#1 clk = 1'b1;
	end

	function automatic logic [15:0] sat(input logic [63:0] r);
		return (r > {48'd0, cap}) ? cap : r[15:0];
	endfunction

	function automatic rates_t query_rates(input logic [63:0] now);
		rates_t      r;
		logic [63:0] lo_edge, gap, gmin, gmax;
		logic [63:0] pick[$];
		bit          any_gap;
		r = '{16'd0, 16'd0, 16'd0};
		any_gap = 0;
		gmin = 0;
		gmax = 0;
		if (filled < 2)
			return r;
		lo_edge = (now > {32'd0, win_us}) ? now - {32'd0, win_us} : 64'd0;
		for (int i = 0; i < filled; i++)
			if (stamps[i] >= lo_edge && stamps[i] <= now)
				pick.push_back(stamps[i]);
		pick.sort();
		if (pick.size() < 2)
			return r;
		if (pick[$] > pick[0])
			r.avg = sat((64'(pick.size() - 1) * 64'd100000000) / (pick[$] - pick[0]));
		for (int i = 1; i < pick.size(); i++) begin
			gap = pick[i] - pick[i - 1];
			if (gap != 0) begin
				if (!any_gap || gap < gmin)
					gmin = gap;
				if (!any_gap || gap > gmax)
					gmax = gap;
				any_gap = 1;
			end
		end
		if (any_gap) begin
			r.max = sat(64'd100000000 / gmin);
			r.min = sat(64'd100000000 / gmax);
		end
		return r;
	endfunction

	// input side: prediction at acceptance
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			tx_taken = 1;
			if (s_tuser[0] == srs_pkg::CMD_RECORD) begin
				stamps[slot] = s_tdata;
				slot = slot + 5'd1;
				if (filled < 32)
					filled++;
			end else begin
				rates_q.push_back(query_rates(s_tdata));
			end
		end
	end

	// output side: compare against oldest expectation
	always @(posedge clk) begin
		rates_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			rx_taken = 1;
			if (rates_q.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				e = rates_q.pop_front();
				if (m_tdata[15:0] !== e.avg || m_tdata[31:16] !== e.min ||
						m_tdata[47:32] !== e.max) begin
					errs++;
					if (errs <= 10)
						$display("mismatch avg/min/max exp %0d %0d %0d got %0d %0d %0d",
							e.avg, e.min, e.max, m_tdata[15:0], m_tdata[31:16],
							m_tdata[47:32]);
				end
			end
		end
	end

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 18);
	endfunction

	// sender
	always @(negedge clk) begin
		word_t w;
		if (arst_n) begin
			if (s_tvalid && tx_taken) begin
				tx_taken = 0;
				if (tx_gap == 0 && word_q.size() != 0) begin
					w = word_q.pop_front();
					s_tdata <= w.stamp;
					s_tuser <= w.cmd;
					if (w.cmd == srs_pkg::CMD_QUERY) queries_sent++; else records_sent++;
					tx_gap = draw_gap(tx_burst);
				end else begin
					s_tvalid <= 1'b0;
				end
			end else if (!s_tvalid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (word_q.size() != 0) begin
					w = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= w.stamp;
					s_tuser <= w.cmd;
					if (w.cmd == srs_pkg::CMD_QUERY) queries_sent++; else records_sent++;
					tx_gap = draw_gap(tx_burst);
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 0;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_taken) begin
				rx_taken = 0;
				rx_gap = draw_gap(rx_burst);
				m_tready <= (rx_gap == 0);
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= (rx_gap == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic wait_idle();
		wait (word_q.size() == 0 && !s_tvalid && rates_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == srs_pkg::REG_WINDOW)
			win_us = val;
		else
			cap = val[15:0];
	endtask

	task automatic push(input logic cmd, input logic [63:0] t);
		word_q.push_back('{cmd, t});
	endtask

	// mostly increasing stamps with repeats and a few steps back, queries near the head
	task automatic stream(input int count, input int step_max);
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			if (k < 25) begin
				k = $urandom_range(0, 9);
				if (k < 6)
					push(srs_pkg::CMD_QUERY, t_cur + $urandom_range(0, step_max));
				else if (k < 8)
					push(srs_pkg::CMD_QUERY, t_cur - $urandom_range(0, 4 * step_max));
				else
					push(srs_pkg::CMD_QUERY, {$urandom, $urandom});
			end else begin
				k = $urandom_range(0, 99);
				if (k < 10)
					;
				else if (k < 15)
					t_cur = t_cur - $urandom_range(0, step_max);
				else if (k < 18)
					t_cur = {$urandom, $urandom};
				else
					t_cur = t_cur + $urandom_range(1, step_max);
				push(srs_pkg::CMD_RECORD, t_cur);
			end
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = srs_pkg::CMD_RECORD;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = srs_pkg::REG_WINDOW;
		cfg_data = '0;
		arst_n = 1'b0;
		win_us = srs_pkg::WINDOW_RESET;
		cap = srs_pkg::CAP_RESET;
		slot = '0;
		filled = 0;
		errs = 0;
		tx_gap = 0;
		rx_gap = 0;
		hold_left = 0;
		hold_req = 0;
		tx_taken = 0;
		rx_taken = 0;
		tx_burst = 0;
		rx_burst = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty store, single stamp, extremes of time
		push(srs_pkg::CMD_QUERY, 64'd0);
		push(srs_pkg::CMD_RECORD, 64'd1000);
		push(srs_pkg::CMD_QUERY, 64'd1000);
		push(srs_pkg::CMD_RECORD, 64'd1000);
		push(srs_pkg::CMD_QUERY, 64'd1000);
		push(srs_pkg::CMD_RECORD, 64'd11000);
		push(srs_pkg::CMD_RECORD, 64'd11500);
		push(srs_pkg::CMD_RECORD, 64'd2000000);
		push(srs_pkg::CMD_QUERY, 64'd3000000);
		push(srs_pkg::CMD_QUERY, 64'd5);
		push(srs_pkg::CMD_QUERY, 64'd100000000);
		push(srs_pkg::CMD_RECORD, 64'd2000001);
		push(srs_pkg::CMD_QUERY, 64'd2000001);
		push(srs_pkg::CMD_RECORD, '1);
		push(srs_pkg::CMD_RECORD, 64'hffff_ffff_ffff_fffe);
		push(srs_pkg::CMD_QUERY, '1);
		push(srs_pkg::CMD_RECORD, 64'd0);
		push(srs_pkg::CMD_QUERY, 64'd500);
		write_reg(srs_pkg::REG_CAP, 32'd0);
		push(srs_pkg::CMD_QUERY, 64'd2000001);
		write_reg(srs_pkg::REG_CAP, 32'd65535);
		write_reg(srs_pkg::REG_WINDOW, 32'd1);
		push(srs_pkg::CMD_QUERY, 64'd2000001);
		write_reg(srs_pkg::REG_WINDOW, 32'hffff_ffff);
		push(srs_pkg::CMD_QUERY, 64'h0000_0001_0000_0000);
		push(srs_pkg::CMD_QUERY, '1);

		t_cur = 64'd0;
		write_reg(srs_pkg::REG_WINDOW, 32'd300000);
		stream(150, 20000);
		hold_req = 1;
		stream(80, 20000);
		wait_idle();
		tx_burst = 1;
		rx_burst = 1;
		stream(60, 100);
		write_reg(srs_pkg::REG_CAP, 32'd500);
		tx_burst = 0;
		rx_burst = 0;
		t_cur = {$urandom, $urandom};
		stream(120, 200000);
		write_reg(srs_pkg::REG_WINDOW, $urandom);
		write_reg(srs_pkg::REG_CAP, $urandom_range(0, 65535));
		stream(120, 2000000);
		write_reg(srs_pkg::REG_WINDOW, 32'd1);
		write_reg(srs_pkg::REG_CAP, 32'd65535);
		stream(60, 3);
		write_reg(srs_pkg::REG_WINDOW, 32'hffff_ffff);
		rx_burst = 1;
		stream(150, 50000);

		wait_idle();
		$display("%0d records and %0d queries sent, %0d results checked, %0d mismatches",
			records_sent, queries_sent, results_seen, errs);
		if (errs == 0)
			$display("** sample_rate_statistics: PASSED **");
		else
			$display("** sample_rate_statistics: FAILED **");
		$finish;
	end

	initial begin
		#40000000;
		$display("timeout waiting for results");
		$display("** sample_rate_statistics: FAILED **");
		$finish;
	end

endmodule
